>>> src/pjec_pkg.sv
// ----------------------------------------------------------------------------
// pjec_pkg
// shared types, constants and saturating helpers for the julia escape counter
// ----------------------------------------------------------------------------
package pjec_pkg;

  localparam int MAX_COEFS  = 6;
  localparam int FRAC_BITS  = 28;
  localparam int CW         = 32;
  localparam int PW         = 2 * CW;
  localparam int LIMIT_W    = 10;
  localparam int RADIUS_W   = 31;
  localparam int RSQ_W      = 2 * RADIUS_W;
  localparam int COEF_REGS  = 6;
  localparam int CREG_W     = $clog2(COEF_REGS);
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_W      = 64;
  localparam int RING_DEPTH = 3;
  localparam int TAG_W      = $clog2(RING_DEPTH + 1);
  localparam int K_W        = $clog2(MAX_COEFS);

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(536870912);
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(100);

  localparam logic [CFG_IDX_W-1:0] REG_COEF_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_3 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_4 = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_5 = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = CFG_IDX_W'(7);

  localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic {PH_TEST, PH_MAC} phase_t;

  typedef logic [COEF_REGS-1:0][PW-1:0] coef_arr_t;

  // one point in flight around the ring
  typedef struct packed {
    logic                valid;
    logic [TAG_W-1:0]    tag;
    logic                done;
    phase_t              phase;
    logic [K_W-1:0]      k;
    logic [LIMIT_W-1:0]  count;
    logic signed [CW-1:0] zr;
    logic signed [CW-1:0] zi;
    logic signed [CW-1:0] ar;
    logic signed [CW-1:0] ai;
  } slot_t;

  typedef struct packed {
    logic signed [PW-1:0] p_rr;
    logic signed [PW-1:0] p_ii;
    logic signed [PW-1:0] p_ri;
    logic signed [PW-1:0] p_ir;
  } prod_t;

  typedef struct packed {
    logic signed [CW-1:0] pr;
    logic signed [CW-1:0] pi;
    logic                 in_radius;
  } comb_t;

  // arithmetic shift down by the fraction width, then clamp to CW bits
  function automatic logic signed [CW-1:0] shift_sat(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] s;
    s = x >>> FRAC_BITS;
    if ((&s[PW-1:CW-1]) || !(|s[PW-1:CW-1])) begin
      return s[CW-1:0];
    end else begin
      return s[PW-1] ? SAT_MIN : SAT_MAX;
    end
  endfunction

  function automatic logic signed [CW-1:0] add_sat(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    if (s[CW] != s[CW-1]) begin
      return s[CW] ? SAT_MIN : SAT_MAX;
    end else begin
      return s[CW-1:0];
    end
  endfunction

endpackage

>>> src/pjec_mul.sv
// ----------------------------------------------------------------------------
// pjec_mul
// ring stage one: four signed 32x32 products of the complex operands
// ----------------------------------------------------------------------------
module pjec_mul (
  input  logic            clk,
  input  logic            rst,
  input  pjec_pkg::slot_t slot_in,
  output pjec_pkg::slot_t slot_out,
  output pjec_pkg::prod_t prod_out
);
  import pjec_pkg::*;

  logic signed [CW-1:0] op_r;
  logic signed [CW-1:0] op_i;

  // magnitude pass squares z, horner pass multiplies acc by z
  always_comb begin
    op_r = (slot_in.phase == PH_TEST) ? slot_in.zr : slot_in.ar;
    op_i = (slot_in.phase == PH_TEST) ? slot_in.zi : slot_in.ai;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_out.valid <= 1'b0;
    end else begin
      slot_out.valid <= slot_in.valid;
    end
    slot_out.tag   <= slot_in.tag;
    slot_out.done  <= slot_in.done;
    slot_out.phase <= slot_in.phase;
    slot_out.k     <= slot_in.k;
    slot_out.count <= slot_in.count;
    slot_out.zr    <= slot_in.zr;
    slot_out.zi    <= slot_in.zi;
    slot_out.ar    <= slot_in.ar;
    slot_out.ai    <= slot_in.ai;
    prod_out.p_rr  <= PW'(op_r) * PW'(slot_in.zr);
    prod_out.p_ii  <= PW'(op_i) * PW'(slot_in.zi);
    prod_out.p_ri  <= PW'(op_r) * PW'(slot_in.zi);
    prod_out.p_ir  <= PW'(op_i) * PW'(slot_in.zr);
  end

endmodule

>>> src/pjec_norm.sv
// ----------------------------------------------------------------------------
// pjec_norm
// ring stage two: product combine, rescale and clamp, radius compare
// ----------------------------------------------------------------------------
module pjec_norm (
  input  logic                         clk,
  input  logic                         rst,
  input  pjec_pkg::slot_t              slot_in,
  input  pjec_pkg::prod_t              prod_in,
  input  logic [pjec_pkg::RSQ_W-1:0]   radius_sq,
  output pjec_pkg::slot_t              slot_out,
  output pjec_pkg::comb_t              comb_out
);
  import pjec_pkg::*;

  logic signed [PW-1:0] re_sum;
  logic signed [PW-1:0] im_sum;
  logic [PW-1:0]        mag2;

  // sums wrap at 64 bits
  always_comb begin
    re_sum = prod_in.p_rr - prod_in.p_ii;
    im_sum = prod_in.p_ri + prod_in.p_ir;
    mag2   = $unsigned(prod_in.p_rr) + $unsigned(prod_in.p_ii);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_out.valid <= 1'b0;
    end else begin
      slot_out.valid <= slot_in.valid;
    end
    slot_out.tag       <= slot_in.tag;
    slot_out.done      <= slot_in.done;
    slot_out.phase     <= slot_in.phase;
    slot_out.k         <= slot_in.k;
    slot_out.count     <= slot_in.count;
    slot_out.zr        <= slot_in.zr;
    slot_out.zi        <= slot_in.zi;
    slot_out.ar        <= slot_in.ar;
    slot_out.ai        <= slot_in.ai;
    comb_out.pr        <= shift_sat(re_sum);
    comb_out.pi        <= shift_sat(im_sum);
    comb_out.in_radius <= (mag2 <= PW'(radius_sq));
  end

endmodule

>>> src/pjec_update.sv
// ----------------------------------------------------------------------------
// pjec_update
// ring stage three: coefficient add and per-point iteration control
// ----------------------------------------------------------------------------
module pjec_update (
  input  logic                          clk,
  input  logic                          rst,
  input  pjec_pkg::slot_t               slot_in,
  input  pjec_pkg::comb_t               comb_in,
  input  pjec_pkg::coef_arr_t           coefs,
  input  logic [pjec_pkg::LIMIT_W-1:0]  iteration_limit,
  output pjec_pkg::slot_t               slot_out
);
  import pjec_pkg::*;

  slot_t                slot_next;
  logic [PW-1:0]        coef;
  logic signed [CW-1:0] acc_r;
  logic signed [CW-1:0] acc_i;

  always_comb begin
    coef      = coefs[slot_in.k];
    acc_r     = add_sat(comb_in.pr, coef[PW-1:CW]);
    acc_i     = add_sat(comb_in.pi, coef[CW-1:0]);
    slot_next = slot_in;
    if (slot_in.valid && !slot_in.done) begin
      case (slot_in.phase)
        PH_TEST: begin
          if ((slot_in.count < iteration_limit) && comb_in.in_radius) begin
            slot_next.phase = PH_MAC;
            slot_next.k     = '0;
            slot_next.ar    = '0;
            slot_next.ai    = '0;
          end else begin
            slot_next.done = 1'b1;
          end
        end
        PH_MAC: begin
          slot_next.ar = acc_r;
          slot_next.ai = acc_i;
          if (slot_in.k == K_W'(MAX_COEFS - 1)) begin
            slot_next.zr    = acc_r;
            slot_next.zi    = acc_i;
            slot_next.count = slot_in.count + LIMIT_W'(1);
            slot_next.phase = PH_TEST;
          end else begin
            slot_next.k = slot_in.k + K_W'(1);
          end
        end
        default: begin
          slot_next.done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_out.valid <= 1'b0;
    end else begin
      slot_out.valid <= slot_next.valid;
    end
    slot_out.tag   <= slot_next.tag;
    slot_out.done  <= slot_next.done;
    slot_out.phase <= slot_next.phase;
    slot_out.k     <= slot_next.k;
    slot_out.count <= slot_next.count;
    slot_out.zr    <= slot_next.zr;
    slot_out.zi    <= slot_next.zi;
    slot_out.ar    <= slot_next.ar;
    slot_out.ai    <= slot_next.ai;
  end

endmodule

>>> src/polynomial_julia_escape_count.sv
// ----------------------------------------------------------------------------
// polynomial_julia_escape_count
// escape-time counter for a julia set of a complex polynomial of degree five
// ----------------------------------------------------------------------------
// Each input word is a start point z (signed Q4.28 real and imaginary). The
// block repeats z = P(z) while the count is below iteration_limit and
// |z|^2 <= escape_radius^2, and returns one word per point: the count and a
// bounded flag. Points move around a three-stage ring (multiply, rescale and
// clamp, coefficient add) that holds up to three points at once; each trip
// around the ring is one Horner step or one magnitude test, so one iteration
// costs seven trips. New points enter while others circulate, whenever the
// ring entry is free. Results leave in input order: a finished point keeps
// circulating until it is the oldest and the output register is free. The
// user must write coefficients, radius and limit only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module polynomial_julia_escape_count (
  input  logic                            clk,
  input  logic                            rst,
  // configuration writes
  input  logic                            cfg_write,
  input  logic [pjec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pjec_pkg::CFG_W-1:0]      cfg_data,
  // start point words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [pjec_pkg::CW-1:0]  start_real,
  input  logic signed [pjec_pkg::CW-1:0]  start_imag,
  // result words
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pjec_pkg::LIMIT_W-1:0]    escape_count,
  output logic                            bounded
);
  import pjec_pkg::*;

  // configuration registers
  coef_arr_t            coefs;
  logic [RADIUS_W-1:0]  escape_radius;
  logic [LIMIT_W-1:0]   iteration_limit;
  logic [RSQ_W-1:0]     radius_sq;

  // ring stages
  slot_t                feed;
  slot_t                s1;
  slot_t                s2;
  slot_t                s3;
  prod_t                prod;
  comb_t                comb;

  // ordering tags
  logic [TAG_W-1:0]     issue_tag;
  logic [TAG_W-1:0]     retire_tag;
  logic                 retire;
  logic                 cont;
  logic                 accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs           <= '0;
      escape_radius   <= RADIUS_RESET;
      iteration_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      if (cfg_index < CFG_IDX_W'(COEF_REGS)) begin
        coefs[cfg_index[CREG_W-1:0]] <= cfg_data;
      end else if (cfg_index == REG_RADIUS) begin
        escape_radius <= cfg_data[RADIUS_W-1:0];
      end else if (cfg_index == REG_LIMIT) begin
        iteration_limit <= cfg_data[LIMIT_W-1:0];
      end
    end
  end

  // radius squared is registered from the radius register, in the cycle after it changes
  always_ff @(posedge clk) begin
    radius_sq <= RSQ_W'(escape_radius) * RSQ_W'(escape_radius);
  end

  // the oldest finished point leaves when the output register can take it
  assign retire   = s3.valid && s3.done && (s3.tag == retire_tag)
                    && (!out_valid || out_ready);
  assign cont     = s3.valid && !retire;
  assign in_ready = !cont;
  assign accept   = in_valid && in_ready;

  // ring entry: a circulating point, else a new start point, else a bubble
  always_comb begin
    if (cont) begin
      feed = s3;
    end else begin
      feed       = '0;
      feed.valid = accept;
      feed.tag   = issue_tag;
      feed.done  = 1'b0;
      feed.phase = PH_TEST;
      feed.count = LIMIT_W'(1);
      feed.zr    = start_real;
      feed.zi    = start_imag;
    end
  end

  pjec_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .slot_in  (feed),
    .slot_out (s1),
    .prod_out (prod)
  );

  pjec_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .slot_in   (s1),
    .prod_in   (prod),
    .radius_sq (radius_sq),
    .slot_out  (s2),
    .comb_out  (comb)
  );

  pjec_update u_update (
    .clk             (clk),
    .rst             (rst),
    .slot_in         (s2),
    .comb_in         (comb),
    .coefs           (coefs),
    .iteration_limit (iteration_limit),
    .slot_out        (s3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_tag  <= '0;
      retire_tag <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        issue_tag <= issue_tag + TAG_W'(1);
      end
      if (retire) begin
        retire_tag <= retire_tag + TAG_W'(1);
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (retire) begin
      escape_count <= s3.count;
      bounded      <= (s3.count == iteration_limit);
    end
  end

  // every issued and not yet retired point sits in exactly one ring stage
  a_ring_occupancy: assert property (@(posedge clk) disable iff (rst)
    $countones({s1.valid, s2.valid, s3.valid}) == int'(TAG_W'(issue_tag - retire_tag)))
    else $error("ring occupancy does not match outstanding points");

  // a retiring point never overruns a held result
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !retire)
    else $error("result overwritten while held");

  // reported count stays within the limit, or is one when the limit is zero
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((escape_count <= iteration_limit && escape_count != '0)
                   || (iteration_limit == '0 && escape_count == LIMIT_W'(1))))
    else $error("escape count out of range");

  // an accepted point enters the first ring stage as a new, unfinished point with a count of one
  a_entry_slot: assert property (@(posedge clk) disable iff (rst)
    accept |=> (s1.valid && !s1.done && s1.count == LIMIT_W'(1)))
    else $error("accepted point lost at ring entry");

endmodule
